// File: design/p2c_pkg.sv
// Shared types, constants and the quarter-wave sine table for the polar-to-Cartesian converter.
// No dependencies; every other design file imports this package.
package p2c_pkg;

	// Default number of fractional bits on x_pos and y_pos
	localparam int FRAC_BITS_DEF = 8;

	// Field widths
	localparam int ANGLE_W = 9;
	localparam int MAG_W   = 16;
	localparam int POS_W   = 25;

	// Sine table format: unsigned Q30, 0 to 90 degrees inclusive
	localparam int TAB_FRAC    = 30;
	localparam int TAB_W       = TAB_FRAC + 1;
	localparam int TAB_DEPTH   = 91;
	localparam int IDX_W       = 7;
	localparam int PROD_W      = MAG_W + TAB_W;
	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic [TAB_W-1:0] ONE_Q30 = TAB_W'(1) << TAB_FRAC;

	// Angle reduction constants
	localparam logic [ANGLE_W-1:0] DEG_90  = ANGLE_W'(90);
	localparam logic [ANGLE_W-1:0] DEG_180 = ANGLE_W'(180);
	localparam logic [ANGLE_W-1:0] DEG_270 = ANGLE_W'(270);
	localparam logic [ANGLE_W-1:0] DEG_360 = ANGLE_W'(360);
	localparam logic [IDX_W-1:0]   IDX_90  = IDX_W'(90);

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	typedef logic [TAB_W-1:0] sine_tab_t [0:TAB_DEPTH-1];

	// Reduced angle going from the reduce stage to the lookup stage
	typedef struct packed {
		logic             valid;
		quad_t            quad;
		logic [IDX_W-1:0] rem;
		logic [MAG_W-1:0] mag;
	} red_t;

	// Selected sine fractions and signs going to the scale stages
	typedef struct packed {
		logic             valid;
		logic             neg_x;
		logic             neg_y;
		logic [TAB_W-1:0] frac_x;
		logic [TAB_W-1:0] frac_y;
		logic [MAG_W-1:0] mag;
	} lkp_t;

	// Integer Taylor series of sin(k degrees) in Q30, evaluated at elaboration
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t               tab;
		logic [63:0]             x;
		logic [63:0]             x2;
		logic [63:0]             term;
		logic signed [63:0]      acc;
		logic [63:0]             half;
		half = 64'd1 << (TAB_FRAC - 1);
		for (int k = 0; k < TAB_DEPTH; k++) begin
			x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
			x2   = (x * x + half) >> TAB_FRAC;
			term = x;
			acc  = signed'(x);
			for (int n = 1; n <= 10; n++) begin
				term = (term * x2 + half) >> TAB_FRAC;
				// divide by (2n)(2n+1), rounded
				case (n)
					1:       term = (term + 64'd3) / 64'd6;
					2:       term = (term + 64'd10) / 64'd20;
					3:       term = (term + 64'd21) / 64'd42;
					4:       term = (term + 64'd36) / 64'd72;
					5:       term = (term + 64'd55) / 64'd110;
					6:       term = (term + 64'd78) / 64'd156;
					7:       term = (term + 64'd105) / 64'd210;
					8:       term = (term + 64'd136) / 64'd272;
					9:       term = (term + 64'd171) / 64'd342;
					default: term = (term + 64'd210) / 64'd420;
				endcase
				if (n[0])
					acc = acc - signed'(term);
				else
					acc = acc + signed'(term);
			end
			if (acc < 0)
				acc = 0;
			if (acc > signed'(64'd1 << TAB_FRAC))
				acc = signed'(64'd1 << TAB_FRAC);
			tab[k] = TAB_W'(acc);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// File: design/p2c_reduce.sv
// Stage 1: folds the angle into 0..359 and splits it into quadrant and remainder.
// Depends on p2c_pkg.
module p2c_reduce
	import p2c_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [ANGLE_W-1:0] angle_deg,
	input  logic [MAG_W-1:0]   magnitude,
	output red_t               red
);

	logic [ANGLE_W-1:0] ang_wrap;
	logic [ANGLE_W-1:0] rem_full;
	quad_t              quad;
	logic               valid_s1;
	quad_t              quad_s1;
	logic [IDX_W-1:0]   rem_s1;
	logic [MAG_W-1:0]   mag_s1;

	// 360..511 wrap to 0..151
	assign ang_wrap = (angle_deg >= DEG_360) ? angle_deg - DEG_360 : angle_deg;

	// quadrant and angle within it
	always_comb begin
		if (ang_wrap < DEG_90) begin
			quad     = QUAD_0;
			rem_full = ang_wrap;
		end else if (ang_wrap < DEG_180) begin
			quad     = QUAD_1;
			rem_full = ang_wrap - DEG_90;
		end else if (ang_wrap < DEG_270) begin
			quad     = QUAD_2;
			rem_full = ang_wrap - DEG_180;
		end else begin
			quad     = QUAD_3;
			rem_full = ang_wrap - DEG_270;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		quad_s1 <= quad;
		rem_s1  <= rem_full[IDX_W-1:0];
		mag_s1  <= magnitude;
	end

	assign red = '{valid: valid_s1, quad: quad_s1, rem: rem_s1, mag: mag_s1};

endmodule

// File: design/p2c_lookup.sv
// Stage 2: reads the quarter-wave sine table and picks fraction and sign per axis.
// Depends on p2c_pkg (table and types).
module p2c_lookup
	import p2c_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  red_t red,
	output lkp_t lkp
);

	logic [IDX_W-1:0] idx_x;
	logic [IDX_W-1:0] idx_y;
	logic             neg_x;
	logic             neg_y;
	logic             valid_s2;
	logic             neg_x_s2;
	logic             neg_y_s2;
	logic [TAB_W-1:0] frac_x_s2;
	logic [TAB_W-1:0] frac_y_s2;
	logic [MAG_W-1:0] mag_s2;

	// cos uses sin(90-r) in even quadrants, sin(r) in odd ones; y the other way round
	always_comb begin
		case (red.quad)
			QUAD_0: begin
				idx_x = IDX_90 - red.rem;
				idx_y = red.rem;
				neg_x = 1'b0;
				neg_y = 1'b0;
			end
			QUAD_1: begin
				idx_x = red.rem;
				idx_y = IDX_90 - red.rem;
				neg_x = 1'b1;
				neg_y = 1'b0;
			end
			QUAD_2: begin
				idx_x = IDX_90 - red.rem;
				idx_y = red.rem;
				neg_x = 1'b1;
				neg_y = 1'b1;
			end
			default: begin
				idx_x = red.rem;
				idx_y = IDX_90 - red.rem;
				neg_x = 1'b0;
				neg_y = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else
			valid_s2 <= red.valid;
	end

	always_ff @(posedge clk) begin
		frac_x_s2 <= SINE_TAB[idx_x];
		frac_y_s2 <= SINE_TAB[idx_y];
		neg_x_s2  <= neg_x;
		neg_y_s2  <= neg_y;
		mag_s2    <= red.mag;
	end

	assign lkp = '{valid: valid_s2, neg_x: neg_x_s2, neg_y: neg_y_s2,
		frac_x: frac_x_s2, frac_y: frac_y_s2, mag: mag_s2};

endmodule

// File: design/p2c_scale.sv
// Stages 3 and 4: multiplies magnitude by the sine fractions, rounds and applies sign.
// Depends on p2c_pkg.
module p2c_scale
	import p2c_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lkp_t                    lkp,
	output logic                    out_valid,
	output logic signed [POS_W-1:0] x_out,
	output logic signed [POS_W-1:0] y_out
);

	localparam int SUM_W = PROD_W + FRAC_BITS;
	localparam int EXT_W = SUM_W + POS_W;
	localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (TAB_FRAC - 1);

	logic              valid_s3;
	logic              neg_x_s3;
	logic              neg_y_s3;
	logic [PROD_W-1:0] prod_x_s3;
	logic [PROD_W-1:0] prod_y_s3;
	logic [SUM_W-1:0]  sum_x;
	logic [SUM_W-1:0]  sum_y;
	logic [EXT_W-1:0]  ext_x;
	logic [EXT_W-1:0]  ext_y;
	logic [POS_W-1:0]  rnd_x;
	logic [POS_W-1:0]  rnd_y;
	logic              valid_s4;
	logic [POS_W-1:0]  x_s4;
	logic [POS_W-1:0]  y_s4;

	// stage 3: one multiplier per axis
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else
			valid_s3 <= lkp.valid;
	end

	always_ff @(posedge clk) begin
		prod_x_s3 <= PROD_W'(lkp.mag) * PROD_W'(lkp.frac_x);
		prod_y_s3 <= PROD_W'(lkp.mag) * PROD_W'(lkp.frac_y);
		neg_x_s3  <= lkp.neg_x;
		neg_y_s3  <= lkp.neg_y;
	end

	// stage 4: scale to FRAC_BITS, round half up, drop the Q30 fraction, wrap to 25 bits
	assign sum_x = {prod_x_s3, {FRAC_BITS{1'b0}}} + HALF;
	assign sum_y = {prod_y_s3, {FRAC_BITS{1'b0}}} + HALF;
	assign ext_x = EXT_W'(sum_x);
	assign ext_y = EXT_W'(sum_y);
	assign rnd_x = ext_x[TAB_FRAC+POS_W-1:TAB_FRAC];
	assign rnd_y = ext_y[TAB_FRAC+POS_W-1:TAB_FRAC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s4 <= 1'b0;
		else
			valid_s4 <= valid_s3;
	end

	always_ff @(posedge clk) begin
		x_s4 <= neg_x_s3 ? POS_W'(0) - rnd_x : rnd_x;
		y_s4 <= neg_y_s3 ? POS_W'(0) - rnd_y : rnd_y;
	end

	assign out_valid = valid_s4;
	assign x_out     = signed'(x_s4);
	assign y_out     = signed'(y_s4);

endmodule

// File: design/polar_to_cartesian_top.sv
// Top level of the polar-to-Cartesian converter: reduce, lookup and scale stages.
// Depends on p2c_pkg, p2c_reduce, p2c_lookup and p2c_scale.

// Converts a lidar sample (angle_deg in whole degrees, magnitude unsigned) into
// x_pos = magnitude*cos and y_pos = magnitude*sin, signed with FRAC_BITS fractional
// bits, rounded to nearest. Angles 360..511 wrap modulo 360. An item is taken on
// every clock edge where start is high; busy is always low, so one item per cycle
// is sustained. Each result passes through the four register stages: angle reduction,
// sine table read, multiply, and round/sign. It is marked by a one-cycle done strobe
// and must be captured then: there is no backpressure.
module polar_to_cartesian_top
	import p2c_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [ANGLE_W-1:0]      angle_deg,
	input  logic [MAG_W-1:0]        magnitude,
	output logic                    done,
	output logic signed [POS_W-1:0] x_pos,
	output logic signed [POS_W-1:0] y_pos
);

	red_t red;
	lkp_t lkp;

	// fully pipelined, never stalls
	assign busy = 1'b0;

	p2c_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.angle_deg (angle_deg),
		.magnitude (magnitude),
		.red       (red)
	);

	p2c_lookup u_lookup (
		.clk    (clk),
		.arst_n (arst_n),
		.red    (red),
		.lkp    (lkp)
	);

	p2c_scale #(
		.FRAC_BITS (FRAC_BITS)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.lkp       (lkp),
		.out_valid (done),
		.x_out     (x_pos),
		.y_out     (y_pos)
	);

`ifndef NO_ASSERTIONS
	// every result comes from an item taken earlier at the input
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("done without an item four cycles earlier");

	// every item produces its result
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##4 done)
		else $error("item lost in the pipeline");

	// zero range gives an exact origin, no negative zero
	a_zero_mag: assert property (@(posedge clk) disable iff (!arst_n)
		(start && magnitude == '0) |-> ##4 (x_pos == '0 && y_pos == '0))
		else $error("zero magnitude did not give zero coordinates");

	// a bearing of zero lies on the x axis
	a_on_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(start && angle_deg == '0) |-> ##4 (y_pos == '0 && !x_pos[POS_W-1]))
		else $error("zero bearing left the positive x axis");
`endif

endmodule

// File: sim/tb_polar_to_cartesian_top.sv
// Self-checking testbench for polar_to_cartesian_top: drives lidar samples and checks
// every x_pos/y_pos pair against a fixed-point sine-table predictor held in a scoreboard.
// Depends on p2c_pkg and the polar_to_cartesian_top design files.
module tb_polar_to_cartesian_top;
	timeunit 1ns;
	timeprecision 1ps;
	import p2c_pkg::*;

	localparam int FRAC       = FRAC_BITS_DEF;
	localparam int STALL_MAX  = 1000;
	localparam int PHASE_LEN  = 425;
	localparam int PRINT_MAX  = 40;

	// Predicts x/y for each accepted sample and matches results in order
	class coord_scoreboard;
		typedef struct {
			logic [ANGLE_W-1:0]      angle;
			logic [MAG_W-1:0]        mag;
			logic signed [POS_W-1:0] x;
			logic signed [POS_W-1:0] y;
		} coord_t;

		coord_t      coords_due[$];
		logic [63:0] sine_q30[0:TAB_DEPTH-1];
		int          errors;

		function new();
			for (int k = 0; k < TAB_DEPTH; k++)
				sine_q30[k] = taylor_sine(k);
			errors = 0;
		endfunction

		// sin(k degrees) as unsigned Q30 via a rounded integer Taylor series
		function logic [63:0] taylor_sine(int k);
			logic [63:0]        rad;
			logic [63:0]        rad_sq;
			logic [63:0]        term;
			logic [63:0]        div;
			logic [63:0]        half;
			logic signed [63:0] acc;
			half   = 64'd1 << (TAB_FRAC - 1);
			rad    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
			rad_sq = (rad * rad + half) >> TAB_FRAC;
			term   = rad;
			acc    = signed'(rad);
			for (int n = 1; n <= 10; n++) begin
				div  = 64'(2 * n) * 64'(2 * n + 1);
				term = (term * rad_sq + half) >> TAB_FRAC;
				term = (term + div / 64'd2) / div;
				if (n % 2 == 1)
					acc = acc - signed'(term);
				else
					acc = acc + signed'(term);
			end
			if (acc < 0)
				acc = 0;
			if (acc > signed'(64'd1 << TAB_FRAC))
				acc = signed'(64'd1 << TAB_FRAC);
			return acc;
		endfunction

		// magnitude * fraction, rounded half up on the unsigned value, then signed and wrapped
		function logic [POS_W-1:0] scale_coord(logic [MAG_W-1:0] mag, logic [63:0] frac,
				bit neg);
			logic [63:0] prod;
			prod = ((64'(mag) * frac) << FRAC) + (64'd1 << (TAB_FRAC - 1));
			prod = prod >> TAB_FRAC;
			if (neg)
				prod = 64'd0 - prod;
			return prod[POS_W-1:0];
		endfunction

		function void note_sample(logic [ANGLE_W-1:0] angle, logic [MAG_W-1:0] mag);
			coord_t      c;
			int          a;
			int          rem;
			quad_t       quad;
			logic [63:0] s_lo;
			logic [63:0] s_hi;
			a    = int'(angle) % 360;
			quad = quad_t'(a / 90);
			rem  = a % 90;
			s_lo = sine_q30[rem];
			s_hi = sine_q30[90 - rem];
			c.angle = angle;
			c.mag   = mag;
			case (quad)
				QUAD_0: begin
					c.x = scale_coord(mag, s_hi, 1'b0);
					c.y = scale_coord(mag, s_lo, 1'b0);
				end
				QUAD_1: begin
					c.x = scale_coord(mag, s_lo, 1'b1);
					c.y = scale_coord(mag, s_hi, 1'b0);
				end
				QUAD_2: begin
					c.x = scale_coord(mag, s_hi, 1'b1);
					c.y = scale_coord(mag, s_lo, 1'b1);
				end
				default: begin
					c.x = scale_coord(mag, s_lo, 1'b0);
					c.y = scale_coord(mag, s_hi, 1'b1);
				end
			endcase
			coords_due.push_back(c);
		endfunction

		function int pending();
			return coords_due.size();
		endfunction

		task report_mismatch(string msg);
			if (errors < PRINT_MAX)
				$display("[%0t] MISMATCH %s", $realtime, msg);
			errors++;
		endtask

		task check_coord(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y);
			coord_t c;
			if (coords_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result x=%0d y=%0d", x, y));
			end else begin
				c = coords_due.pop_front();
				if (x !== c.x)
					report_mismatch($sformatf("angle=%0d mag=%0d x_pos got %0d want %0d",
						c.angle, c.mag, x, c.x));
				if (y !== c.y)
					report_mismatch($sformatf("angle=%0d mag=%0d y_pos got %0d want %0d",
						c.angle, c.mag, y, c.y));
			end
		endtask
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [ANGLE_W-1:0]      angle_deg;
	logic [MAG_W-1:0]        magnitude;
	logic                    done;
	logic signed [POS_W-1:0] x_pos;
	logic signed [POS_W-1:0] y_pos;

	coord_scoreboard coords = new();
	int              quiet_cycles = 0;

	polar_to_cartesian_top #(.FRAC_BITS(FRAC)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.angle_deg (angle_deg),
		.magnitude (magnitude),
		.done      (done),
		.x_pos     (x_pos),
		.y_pos     (y_pos)
	);

	// 125 MHz clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Monitor: record accepted samples, check strobed results, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				coords.note_sample(angle_deg, magnitude);
			if (done)
				coords.check_coord(x_pos, y_pos);
		end
		if (arst_n && ((start && !busy) || done))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_MAX) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Leave the line idle with idle_pct odds per cycle, then present one sample until taken
	task drive_sample(logic [ANGLE_W-1:0] angle, logic [MAG_W-1:0] mag, int idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			start     <= 1'b0;
			angle_deg <= ANGLE_W'($urandom);
			magnitude <= MAG_W'($urandom);
			@(posedge clk);
		end
		start     <= 1'b1;
		angle_deg <= angle;
		magnitude <= mag;
		do @(posedge clk); while (busy);
	endtask

	// Hold off until every predicted result has come back
	task drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (coords.pending() != 0)
			@(posedge clk);
	endtask

	function logic [MAG_W-1:0] pick_magnitude();
		case ($urandom_range(0, 7))
			0:       return $urandom_range(0, 1) ? '1 : '0;
			1:       return MAG_W'($urandom_range(0, 15));
			2:       return MAG_W'(16'hFFFF - $urandom_range(0, 15));
			default: return MAG_W'($urandom);
		endcase
	endfunction

	function logic [ANGLE_W-1:0] pick_angle();
		case ($urandom_range(0, 9))
			// quadrant boundaries and their neighbors
			0:       return ANGLE_W'(90 * $urandom_range(0, 5) + $urandom_range(0, 2) - 1);
			// wrapped range above 359
			1:       return ANGLE_W'($urandom_range(360, 511));
			default: return ANGLE_W'($urandom_range(0, 511));
		endcase
	endfunction

	// Sender idle percentage per phase; the receiver has no backpressure to exercise
	int idle_by_phase[4] = '{0, 49, 0, 34};

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		angle_deg = '0;
		magnitude = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: axes, quadrant edges, wrap above 359, zero and full-scale range
		drive_sample(9'd0,   16'hFFFF, 0);
		drive_sample(9'd90,  16'hFFFF, 0);
		drive_sample(9'd180, 16'hFFFF, 0);
		drive_sample(9'd270, 16'hFFFF, 0);
		drive_sample(9'd359, 16'hFFFF, 0);
		drive_sample(9'd1,   16'hFFFF, 0);
		drive_sample(9'd89,  16'hFFFF, 0);
		drive_sample(9'd91,  16'hAAAA, 0);
		drive_sample(9'd179, 16'h5555, 0);
		drive_sample(9'd181, 16'h8000, 0);
		drive_sample(9'd269, 16'h7FFF, 0);
		drive_sample(9'd271, 16'd1,    0);
		drive_sample(9'd45,  16'd1,    0);
		drive_sample(9'd360, 16'd1000, 0);
		drive_sample(9'd450, 16'd1000, 0);
		drive_sample(9'd511, 16'hFFFF, 0);
		drive_sample(9'd256, 16'h0100, 0);
		drive_sample(9'd0,   16'd0,    0);
		drive_sample(9'd135, 16'd0,    0);
		drive_sample(9'd225, 16'd0,    0);
		drive_sample(9'd511, 16'd0,    0);
		drive_sample(9'd315, 16'd2,    0);
		drain_results();

		// Random phases with different sender idle rates, drained between phases
		for (int phase = 0; phase < 4; phase++) begin
			repeat (PHASE_LEN)
				drive_sample(pick_angle(), pick_magnitude(), idle_by_phase[phase]);
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (coords.errors == 0 && coords.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
